/* hw/rtl/sellmeier_index_evaluator_core_assert.svh */
// Assertion macros used by the checker file of the index evaluator.
`ifndef SELLMEIER_INDEX_EVALUATOR_CORE_ASSERT_SVH
`define SELLMEIER_INDEX_EVALUATOR_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define SIE_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("sie assertion failed");

// Next-cycle implication, disabled while reset is low.
`define SIE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("sie assertion failed");

`endif

/* hw/rtl/sie_pkg.sv */
// Shared types and constants of the Sellmeier index evaluator.
package sie_pkg;

  localparam int WAVE_W    = 17;
  localparam int INDEX_W   = 26;
  localparam int B_W       = 32;
  localparam int C_W       = 40;
  localparam int LAM_W     = 42;
  localparam int PROD_W    = 74;
  localparam int QUO_W     = 40;
  localparam int DIV_STEPS = 40;
  localparam int RAD_W     = 44;
  localparam int SQ_IN_W   = 52;
  localparam int ROOT_W    = 26;
  localparam int TERMS     = 3;

  // Register map, one 8-byte slot per register
  typedef enum logic [2:0] {
    REG_B_FIRST  = 3'd0,
    REG_B_SECOND = 3'd1,
    REG_B_THIRD  = 3'd2,
    REG_C_FIRST  = 3'd3,
    REG_C_SECOND = 3'd4,
    REG_C_THIRD  = 3'd5
  } reg_idx_e;

  typedef struct packed {
    logic [TERMS-1:0][B_W-1:0] b;
    logic [TERMS-1:0][C_W-1:0] c;
  } coef_t;

  // State of the three long divisions as it moves down the divider
  typedef struct packed {
    logic                        zero;
    logic [TERMS-1:0]            neg;
    logic [TERMS-1:0]            sat;
    logic [TERMS-1:0][LAM_W-1:0] mag;
    logic [TERMS-1:0][LAM_W-1:0] rem;
    logic [TERMS-1:0][QUO_W-1:0] low;
    logic [TERMS-1:0][QUO_W-1:0] quo;
  } div_t;

  typedef struct packed {
    logic                    err;
    logic signed [RAD_W-1:0] rad;
  } root_in_t;

  typedef struct packed {
    logic               err;
    logic               sat;
    logic [SQ_IN_W-1:0] rem;
    logic [ROOT_W-1:0]  root;
  } sq_t;

endpackage

/* hw/rtl/sie_wave_if.sv */
// Wavelength input channel.
interface sie_wave_if;
  logic                       valid;
  logic                       ready;
  logic [sie_pkg::WAVE_W-1:0] wavelength;

  modport source (output valid, output wavelength, input ready);
  modport sink (input valid, input wavelength, output ready);
endinterface

/* hw/rtl/sie_index_if.sv */
// Refractive index result channel.
interface sie_index_if;
  logic                        valid;
  logic                        ready;
  logic [sie_pkg::INDEX_W-1:0] index_value;
  logic                        math_error;

  modport source (output valid, output index_value, output math_error, input ready);
  modport sink (input valid, input index_value, input math_error, output ready);
endinterface

/* hw/rtl/sellmeier_index_evaluator_core.sv */
// Three-term Sellmeier index evaluator: 72-stage pipeline, one wavelength
// per cycle in, one index per cycle out while the output is not stalled. The
// 72 stages are 4 of squaring, multiplication and divider setup, 41 of
// division (one quotient bit per stage over the three terms, then the term
// sum) and 27 of square root (a range check, then one root bit per stage). A
// stall at the output fills bubbles before it reaches the input.
// The coefficients sit at byte addresses 8*i of the APB port and may only be
// rewritten while no item is in flight.
module sellmeier_index_evaluator_core #(
  parameter int WAVE_FRAC_BITS  = 16,
  parameter int INDEX_FRAC_BITS = 24
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  sie_wave_if.sink           wave_i,
  sie_index_if.source        index_o,
  input  logic               psel_i,
  input  logic               penable_i,
  input  logic               pwrite_i,
  input  logic [5:0]         paddr_i,
  input  logic [63:0]        pwdata_i,
  output logic [63:0]        prdata_o,
  output logic               pready_o
);

  sie_pkg::coef_t    coef_q;
  sie_pkg::reg_idx_e reg_idx;
  logic              wr_en;

  assign pready_o = 1'b1;
  assign reg_idx  = sie_pkg::reg_idx_e'(paddr_i[5:3]);
  assign wr_en    = psel_i && penable_i && pwrite_i;

  // Coefficient registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q <= '0;
    end else if (wr_en) begin
      case (reg_idx)
        sie_pkg::REG_B_FIRST:  coef_q.b[0] <= pwdata_i[sie_pkg::B_W-1:0];
        sie_pkg::REG_B_SECOND: coef_q.b[1] <= pwdata_i[sie_pkg::B_W-1:0];
        sie_pkg::REG_B_THIRD:  coef_q.b[2] <= pwdata_i[sie_pkg::B_W-1:0];
        sie_pkg::REG_C_FIRST:  coef_q.c[0] <= pwdata_i[sie_pkg::C_W-1:0];
        sie_pkg::REG_C_SECOND: coef_q.c[1] <= pwdata_i[sie_pkg::C_W-1:0];
        sie_pkg::REG_C_THIRD:  coef_q.c[2] <= pwdata_i[sie_pkg::C_W-1:0];
        default: ;
      endcase
    end
  end

  // Register readback
  always_comb begin
    case (reg_idx)
      sie_pkg::REG_B_FIRST:  prdata_o = 64'(coef_q.b[0]);
      sie_pkg::REG_B_SECOND: prdata_o = 64'(coef_q.b[1]);
      sie_pkg::REG_B_THIRD:  prdata_o = 64'(coef_q.b[2]);
      sie_pkg::REG_C_FIRST:  prdata_o = 64'(coef_q.c[0]);
      sie_pkg::REG_C_SECOND: prdata_o = 64'(coef_q.c[1]);
      sie_pkg::REG_C_THIRD:  prdata_o = 64'(coef_q.c[2]);
      default:               prdata_o = '0;
    endcase
  end

  // Pipeline sections
  logic              fr_valid, fr_ready;
  sie_pkg::div_t     fr_data;
  logic              dv_valid, dv_ready;
  sie_pkg::root_in_t dv_data;

  sie_front #(
    .WAVE_FRAC_BITS(WAVE_FRAC_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .coef_i      (coef_q),
    .in_valid_i  (wave_i.valid),
    .in_ready_o  (wave_i.ready),
    .wavelength_i(wave_i.wavelength),
    .out_valid_o (fr_valid),
    .out_ready_i (fr_ready),
    .out_data_o  (fr_data)
  );

  sie_divider u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (fr_valid),
    .in_ready_o (fr_ready),
    .in_data_i  (fr_data),
    .out_valid_o(dv_valid),
    .out_ready_i(dv_ready),
    .out_data_o (dv_data)
  );

  sie_sqrt #(
    .INDEX_FRAC_BITS(INDEX_FRAC_BITS)
  ) u_sqrt (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (dv_valid),
    .in_ready_o   (dv_ready),
    .in_data_i    (dv_data),
    .out_valid_o  (index_o.valid),
    .out_ready_i  (index_o.ready),
    .index_value_o(index_o.index_value),
    .math_error_o (index_o.math_error)
  );

endmodule

/* hw/rtl/sie_front.sv */
// Front end: wavelength square, denominators, numerator products, divider setup.
module sie_front #(
  parameter int WAVE_FRAC_BITS = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  sie_pkg::coef_t             coef_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [sie_pkg::WAVE_W-1:0] wavelength_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output sie_pkg::div_t              out_data_o
);

  localparam int LW = sie_pkg::LAM_W;
  localparam int PW = sie_pkg::PROD_W;
  localparam int QW = sie_pkg::QUO_W;
  localparam int T  = sie_pkg::TERMS;

  logic [3:0] vld_q;
  logic [4:0] en;

  // Stage enables: a stage moves when empty or when its successor moves
  assign en[4] = out_ready_i;
  for (genvar s = 0; s < 4; s++) begin : g_en
    assign en[s] = !vld_q[s] || en[s+1];
  end
  assign in_ready_o  = en[0];
  assign out_valid_o = vld_q[3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[0]) vld_q[0] <= in_valid_i;
      for (int s = 1; s < 4; s++) begin
        if (en[s]) vld_q[s] <= vld_q[s-1];
      end
    end
  end

  // Stage 1: lambda squared with 32 fraction bits
  logic [2*sie_pkg::WAVE_W-1:0] sq;
  logic [LW-1:0]                lam_d;
  logic [LW-1:0]                lam_q;

  assign sq = (2*sie_pkg::WAVE_W)'(wavelength_i) * (2*sie_pkg::WAVE_W)'(wavelength_i);
  if (2 * WAVE_FRAC_BITS > 32) begin : g_lam_shr
    assign lam_d = LW'(sq >> (2 * WAVE_FRAC_BITS - 32));
  end else begin : g_lam_shl
    assign lam_d = LW'(sq) << (32 - 2 * WAVE_FRAC_BITS);
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) lam_q <= lam_d;
  end

  // Stage 2: denominator magnitude and sign, split numerator products
  logic [T-1:0][LW-1:0] mag2_d, mag2_q;
  logic [T-1:0]         neg2_d, neg2_q;
  logic [T-1:0]         zero2_d;
  logic                 zero2_q;
  logic [T-1:0][63:0]   lo2_d, lo2_q;
  logic [T-1:0][LW-1:0] hi2_d, hi2_q;

  always_comb begin
    for (int k = 0; k < T; k++) begin
      neg2_d[k]  = lam_q < LW'(coef_i.c[k]);
      zero2_d[k] = lam_q == LW'(coef_i.c[k]);
      mag2_d[k]  = neg2_d[k] ? (LW'(coef_i.c[k]) - lam_q) : (lam_q - LW'(coef_i.c[k]));
      lo2_d[k]   = 64'(coef_i.b[k]) * 64'(lam_q[31:0]);
      hi2_d[k]   = LW'(coef_i.b[k]) * LW'(lam_q[LW-1:32]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      mag2_q  <= mag2_d;
      neg2_q  <= neg2_d;
      zero2_q <= |zero2_d;
      lo2_q   <= lo2_d;
      hi2_q   <= hi2_d;
    end
  end

  // Stage 3: join partial products into B * lambda^2
  logic [T-1:0][PW-1:0] prod3_q;
  logic [T-1:0][LW-1:0] mag3_q;
  logic [T-1:0]         neg3_q;
  logic                 zero3_q;

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      for (int k = 0; k < T; k++) begin
        prod3_q[k] <= PW'(lo2_q[k]) + (PW'(hi2_q[k]) << 32);
      end
      mag3_q  <= mag2_q;
      neg3_q  <= neg2_q;
      zero3_q <= zero2_q;
    end
  end

  // Stage 4: saturation check and initial remainder for the quotient steps
  sie_pkg::div_t div_d, div_q;

  always_comb begin
    div_d      = '0;
    div_d.zero = zero3_q;
    div_d.neg  = neg3_q;
    div_d.mag  = mag3_q;
    for (int k = 0; k < T; k++) begin
      div_d.sat[k] = LW'(prod3_q[k][PW-1:QW]) >= mag3_q[k];
      div_d.rem[k] = div_d.sat[k] ? '0 : LW'(prod3_q[k][PW-1:QW]);
      div_d.low[k] = prod3_q[k][QW-1:0];
      div_d.quo[k] = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[3]) div_q <= div_d;
  end

  assign out_data_o = div_q;

endmodule

/* hw/rtl/sie_divider.sv */
// Pipelined restoring divider, three lanes, one quotient bit per stage, then term sum.
module sie_divider (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  sie_pkg::div_t     in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output sie_pkg::root_in_t out_data_o
);

  localparam int N  = sie_pkg::DIV_STEPS + 1;
  localparam int LW = sie_pkg::LAM_W;
  localparam int QW = sie_pkg::QUO_W;
  localparam int RW = sie_pkg::RAD_W;
  localparam int T  = sie_pkg::TERMS;

  // One quotient step on every lane
  function automatic sie_pkg::div_t div_step(sie_pkg::div_t s);
    sie_pkg::div_t r;
    logic [LW:0]   t;
    r = s;
    for (int k = 0; k < T; k++) begin
      t = {s.rem[k], s.low[k][QW-1]};
      if (t >= {1'b0, s.mag[k]}) begin
        r.rem[k] = LW'(t - {1'b0, s.mag[k]});
        r.quo[k] = {s.quo[k][QW-2:0], 1'b1};
      end else begin
        r.rem[k] = t[LW-1:0];
        r.quo[k] = {s.quo[k][QW-2:0], 1'b0};
      end
      r.low[k] = {s.low[k][QW-2:0], 1'b0};
    end
    return r;
  endfunction

  logic [N-1:0] vld_q;
  logic [N:0]   en;

  assign en[N] = out_ready_i;
  for (genvar s = 0; s < N; s++) begin : g_en
    assign en[s] = !vld_q[s] || en[s+1];
  end
  assign in_ready_o  = en[0];
  assign out_valid_o = vld_q[N-1];

  // Advance valid bits with their stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[0]) vld_q[0] <= in_valid_i;
      for (int s = 1; s < N; s++) begin
        if (en[s]) vld_q[s] <= vld_q[s-1];
      end
    end
  end

  // Quotient step stages
  sie_pkg::div_t st_q [sie_pkg::DIV_STEPS];

  always_ff @(posedge clk_i) begin
    if (en[0]) st_q[0] <= div_step(in_data_i);
    for (int s = 1; s < sie_pkg::DIV_STEPS; s++) begin
      if (en[s]) st_q[s] <= div_step(st_q[s-1]);
    end
  end

  // Sum stage: clamp each term, apply its sign, add one
  sie_pkg::div_t           last;
  logic [T-1:0][QW:0]      term;
  logic signed [RW-1:0]    rad_d;
  sie_pkg::root_in_t       out_q;

  assign last = st_q[sie_pkg::DIV_STEPS-1];

  always_comb begin
    rad_d = RW'(64'sd1 << 30);
    for (int k = 0; k < T; k++) begin
      term[k] = last.sat[k] ? ((QW+1)'(1) << QW) : (QW+1)'(last.quo[k]);
      if (last.neg[k]) rad_d = rad_d - RW'(term[k]);
      else             rad_d = rad_d + RW'(term[k]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[N-1]) begin
      out_q.err <= last.zero;
      out_q.rad <= rad_d;
    end
  end

  assign out_data_o = out_q;

endmodule

/* hw/rtl/sie_sqrt.sv */
// Pipelined digit-by-digit square root with range check and output selection.
module sie_sqrt #(
  parameter int INDEX_FRAC_BITS = 24
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  sie_pkg::root_in_t           in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [sie_pkg::INDEX_W-1:0] index_value_o,
  output logic                        math_error_o
);

  localparam int RTW = sie_pkg::ROOT_W;
  localparam int N   = RTW + 1;
  localparam int VW  = sie_pkg::SQ_IN_W;
  localparam int RW  = sie_pkg::RAD_W;
  localparam int LIM = 82 - 2 * INDEX_FRAC_BITS;
  localparam int SH  = 2 * INDEX_FRAC_BITS - 30;

  logic [N-1:0] vld_q;
  logic [N:0]   en;

  assign en[N] = out_ready_i;
  for (genvar s = 0; s < N; s++) begin : g_en
    assign en[s] = !vld_q[s] || en[s+1];
  end
  assign in_ready_o  = en[0];
  assign out_valid_o = vld_q[N-1];

  // Advance valid bits with their stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[0]) vld_q[0] <= in_valid_i;
      for (int s = 1; s < N; s++) begin
        if (en[s]) vld_q[s] <= vld_q[s-1];
      end
    end
  end

  // Stage 0: sign and zero check, overflow check, scale the radicand
  logic [RW-1:0] rad_u;
  sie_pkg::sq_t  prep_d;
  sie_pkg::sq_t  st_q [N];

  assign rad_u = in_data_i.rad;

  always_comb begin
    prep_d      = '0;
    prep_d.err  = in_data_i.err || rad_u[RW-1] || (rad_u == '0);
    prep_d.sat  = |(rad_u >> LIM);
    prep_d.rem  = VW'(rad_u) << SH;
    prep_d.root = '0;
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) st_q[0] <= prep_d;
  end

  // Root stages, most significant bit first
  for (genvar j = 1; j < N; j++) begin : g_root
    localparam int B = RTW - j;
    sie_pkg::sq_t nxt;
    logic [VW:0]  trial;

    always_comb begin
      nxt   = st_q[j-1];
      trial = ((VW+1)'(st_q[j-1].root) << (B + 1)) | ((VW+1)'(1) << (2 * B));
      if ({1'b0, st_q[j-1].rem} >= trial) begin
        nxt.rem     = VW'({1'b0, st_q[j-1].rem} - trial);
        nxt.root[B] = 1'b1;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en[j]) st_q[j] <= nxt;
    end
  end

  // Select error, saturation or root
  always_comb begin
    if (st_q[N-1].err) begin
      index_value_o = '0;
    end else if (st_q[N-1].sat) begin
      index_value_o = '1;
    end else begin
      index_value_o = st_q[N-1].root;
    end
  end
  assign math_error_o = st_q[N-1].err;

endmodule

/* hw/rtl/sie_checker.sv */
// Port-level checks of the index evaluator, bound to the top level.
`include "sellmeier_index_evaluator_core_assert.svh"

module sie_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        out_valid_i,
  input logic                        out_ready_i,
  input logic [sie_pkg::INDEX_W-1:0] index_value_i,
  input logic                        math_error_i
);

  // Hold a stalled result
  `SIE_ASSERT_NEXT(a_stall_valid, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i)
  `SIE_ASSERT_NEXT(a_stall_data, clk_i, rst_ni, out_valid_i && !out_ready_i, $stable(index_value_i) && $stable(math_error_i))
  // An error result carries a zero index
  `SIE_ASSERT_IMPL(a_err_zero, clk_i, rst_ni, out_valid_i && math_error_i, index_value_i == '0)
  // A saturated index is never flagged as an error
  `SIE_ASSERT_IMPL(a_sat_ok, clk_i, rst_ni, out_valid_i && (index_value_i == '1), !math_error_i)

endmodule

bind sellmeier_index_evaluator_core sie_checker u_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_i  (index_o.valid),
  .out_ready_i  (index_o.ready),
  .index_value_i(index_o.index_value),
  .math_error_i (index_o.math_error)
);
